FILE: sv/csp_pkg.sv
// ----------------------------------------------------------------------------
// csp_pkg
// Shared types and constants for the cylinder support point block.
// ----------------------------------------------------------------------------
package csp_pkg;

  localparam int COORD_WIDTH    = 16;
  localparam int UNIT_FRAC_BITS = 14;

  localparam int VEC_WIDTH  = 48;
  localparam int SCAL_WIDTH = 15;
  localparam int CFG_IDX_W  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER    = 3'd0,
    CFG_AXIS      = 3'd1,
    CFG_HALF_AXIS = 3'd2,
    CFG_RADIUS    = 3'd3,
    CFG_EPSILON   = 3'd4
  } cfg_idx_e;

  localparam logic [SCAL_WIDTH-1:0] EPSILON_RESET = 15'd2;

  typedef struct packed {
    logic signed [15:0] dir_z;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_x;
  } dir_t;

  typedef struct packed {
    logic signed [15:0] point_z;
    logic signed [15:0] point_y;
    logic signed [15:0] point_x;
  } point_t;

endpackage

FILE: sv/cylinder_support_point.sv
// ----------------------------------------------------------------------------
// cylinder_support_point
// Support mapping of a configured cylinder for collision detection.
// ----------------------------------------------------------------------------
// Accepts one direction every clock cycle, unless the output stalls, and
// returns its support point. The pipeline has six stages of dot
// product, axial removal and squared length, one stage per result bit of the
// 28-bit square root of the radial length, one setup stage, one stage per
// quotient bit of the 15-bit radius division, and the output register. The
// whole pipeline holds while a result waits at the output. Configuration
// writes are taken every cycle and must happen while no transaction is in
// flight.
module cylinder_support_point
  import csp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  dir_t                  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output point_t                out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [VEC_WIDTH-1:0]  cfg_data_i
);

  localparam int F     = UNIT_FRAC_BITS;
  localparam int PW    = 32;
  localparam int DW    = 34;
  localparam int PPW   = 50;
  localparam int RDW   = 22;
  localparam int RW    = 20;
  localparam int L2W   = 40;
  localparam int VW    = 56;
  localparam int LW    = 28;
  localparam int REMW  = 30;
  localparam int NKW   = 35;
  localparam int MW    = 43;
  localparam int QW    = 15;
  localparam int SW    = 19;
  localparam int SQN   = LW;
  localparam int ES2W  = 2 * SCAL_WIDTH;
  localparam logic signed [SW-1:0] SAT_HI = SW'((1 <<< (COORD_WIDTH - 1)) - 1);
  localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

  typedef struct packed {
    logic use_rad;
    logic pos;
    logic neg;
  } tag_t;

  // configuration
  logic [VEC_WIDTH-1:0]  center_q, axis_q, half_q;
  logic [SCAL_WIDTH-1:0] radius_q, eps_q;
  logic [ES2W-1:0]       eps_sq_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q <= '0;
      axis_q   <= '0;
      half_q   <= '0;
      radius_q <= '0;
      eps_q    <= EPSILON_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_CENTER:    center_q <= cfg_data_i;
        CFG_AXIS:      axis_q   <= cfg_data_i;
        CFG_HALF_AXIS: half_q   <= cfg_data_i;
        CFG_RADIUS:    radius_q <= cfg_data_i[SCAL_WIDTH-1:0];
        CFG_EPSILON:   eps_q    <= cfg_data_i[SCAL_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    eps_sq_q <= eps_q * eps_q;
  end

  logic signed [15:0] axis_l [3];
  logic signed [15:0] center_l [3];
  logic signed [15:0] half_l [3];
  logic signed [15:0] din [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      axis_l[k]   = axis_q[16*k +: 16];
      center_l[k] = center_q[16*k +: 16];
      half_l[k]   = half_q[16*k +: 16];
    end
    din[0] = in_data_i.dir_x;
    din[1] = in_data_i.dir_y;
    din[2] = in_data_i.dir_z;
  end

  // pipeline control
  logic en;
  logic out_valid_q;
  logic a_vld_q, b_vld_q, c_vld_q, d_vld_q, e_vld_q, f_vld_q, g_vld_q;
  logic sq_vld_q [SQN];
  logic dv_vld_q [QW];

  assign en          = !out_valid_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q     <= 1'b0;
      b_vld_q     <= 1'b0;
      c_vld_q     <= 1'b0;
      d_vld_q     <= 1'b0;
      e_vld_q     <= 1'b0;
      f_vld_q     <= 1'b0;
      g_vld_q     <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < SQN; i++) sq_vld_q[i] <= 1'b0;
      for (int j = 0; j < QW; j++) dv_vld_q[j] <= 1'b0;
    end else if (en) begin
      a_vld_q <= in_valid_i;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
      d_vld_q <= c_vld_q;
      e_vld_q <= d_vld_q;
      f_vld_q <= e_vld_q;
      sq_vld_q[0] <= f_vld_q;
      for (int i = 1; i < SQN; i++) sq_vld_q[i] <= sq_vld_q[i-1];
      g_vld_q <= sq_vld_q[SQN-1];
      dv_vld_q[0] <= g_vld_q;
      for (int j = 1; j < QW; j++) dv_vld_q[j] <= dv_vld_q[j-1];
      out_valid_q <= dv_vld_q[QW-1];
    end
  end

  // stage A: component products
  logic signed [15:0]  a_d_q [3];
  logic signed [PW-1:0] a_prod_q [3];
  // stage B: dot product and cap choice
  logic signed [15:0]  b_d_q [3];
  logic signed [DW-1:0] b_dot_q;
  logic                b_pos_q, b_neg_q;
  // stage C: axial projection
  logic signed [15:0]   c_d_q [3];
  logic signed [PPW-1:0] c_p_q [3];
  logic                 c_pos_q, c_neg_q;
  // stage D: radial remainder
  logic signed [RW-1:0] d_r_q [3];
  logic                 d_pos_q, d_neg_q;
  // stage E: squares and radius products
  logic [L2W-1:0]        e_sq_q [3];
  logic signed [NKW-1:0] e_nk_q [3];
  logic                  e_pos_q, e_neg_q;
  // stage F: squared length
  logic [L2W-1:0]        f_len2_q;
  logic signed [NKW-1:0] f_nk_q [3];
  tag_t                  f_tag_q;

  logic signed [PPW-1:0] c_p_rnd [3];
  logic signed [PPW-1:0] c_p_sh [3];
  logic signed [DW-1:0]  thr;
  logic [L2W-1:0]        e_len2;

  always_comb begin
    thr = DW'({eps_q, F'(0)});
    for (int k = 0; k < 3; k++) begin
      c_p_rnd[k] = c_p_q[k] + (PPW'(1) <<< (2 * F - 1));
      c_p_sh[k]  = c_p_rnd[k] >>> (2 * F);
    end
    e_len2 = e_sq_q[0] + e_sq_q[1] + e_sq_q[2];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        a_d_q[k]    <= din[k];
        a_prod_q[k] <= din[k] * axis_l[k];
        b_d_q[k]    <= a_d_q[k];
        c_d_q[k]    <= b_d_q[k];
        c_p_q[k]    <= PPW'(b_dot_q) * PPW'(axis_l[k]);
        d_r_q[k]    <= RW'(RDW'(c_d_q[k]) - RDW'(c_p_sh[k]));
        e_sq_q[k]   <= L2W'(d_r_q[k]) * L2W'(d_r_q[k]);
        e_nk_q[k]   <= NKW'(d_r_q[k]) * $signed(NKW'(radius_q));
        f_nk_q[k]   <= e_nk_q[k];
      end
      b_dot_q <= DW'(a_prod_q[0]) + DW'(a_prod_q[1]) + DW'(a_prod_q[2]);
      b_pos_q <= (DW'(a_prod_q[0]) + DW'(a_prod_q[1]) + DW'(a_prod_q[2])) > thr;
      b_neg_q <= (DW'(a_prod_q[0]) + DW'(a_prod_q[1]) + DW'(a_prod_q[2])) < -thr;
      c_pos_q <= b_pos_q;
      c_neg_q <= b_neg_q;
      d_pos_q <= c_pos_q;
      d_neg_q <= c_neg_q;
      e_pos_q <= d_pos_q;
      e_neg_q <= d_neg_q;
      f_len2_q        <= e_len2;
      f_tag_q.use_rad <= e_len2 > L2W'(eps_sq_q);
      f_tag_q.pos     <= e_pos_q;
      f_tag_q.neg     <= e_neg_q;
    end
  end

  // square root: one result bit per stage
  logic [REMW-1:0]       sq_rem_q [SQN], sq_rem_d [SQN];
  logic [LW-1:0]         sq_root_q [SQN], sq_root_d [SQN];
  logic [VW-1:0]         sq_v_q [SQN], sq_v_d [SQN];
  logic signed [NKW-1:0] sq_nk_q [SQN][3];
  tag_t                  sq_tag_q [SQN];

  always_comb begin
    logic [REMW-1:0] rem_p;
    logic [LW-1:0]   root_p;
    logic [VW-1:0]   v_p;
    logic [REMW+1:0] remx;
    logic [REMW+1:0] trial;
    for (int i = 0; i < SQN; i++) begin
      if (i == 0) begin
        rem_p  = '0;
        root_p = '0;
        v_p    = {f_len2_q, 16'b0};
      end else begin
        rem_p  = sq_rem_q[i-1];
        root_p = sq_root_q[i-1];
        v_p    = sq_v_q[i-1];
      end
      remx  = {rem_p, v_p[VW-1 -: 2]};
      trial = (REMW+2)'({root_p, 2'b01});
      sq_v_d[i] = v_p << 2;
      if (remx >= trial) begin
        sq_rem_d[i]  = REMW'(remx - trial);
        sq_root_d[i] = {root_p[LW-2:0], 1'b1};
      end else begin
        sq_rem_d[i]  = REMW'(remx);
        sq_root_d[i] = {root_p[LW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < SQN; i++) begin
        sq_rem_q[i]  <= sq_rem_d[i];
        sq_root_q[i] <= sq_root_d[i];
        sq_v_q[i]    <= sq_v_d[i];
      end
      sq_tag_q[0] <= f_tag_q;
      for (int k = 0; k < 3; k++) sq_nk_q[0][k] <= f_nk_q[k];
      for (int i = 1; i < SQN; i++) begin
        sq_tag_q[i] <= sq_tag_q[i-1];
        for (int k = 0; k < 3; k++) sq_nk_q[i][k] <= sq_nk_q[i-1][k];
      end
    end
  end

  // stage G: division setup
  logic [MW-1:0] g_mag_q [3];
  logic          g_neg_q [3];
  logic [LW-1:0] g_len_q;
  tag_t          g_tag_q;

  logic [LW-1:0]  len_s;
  logic [NKW-1:0] nk_abs [3];

  always_comb begin
    len_s = sq_root_q[SQN-1];
    for (int k = 0; k < 3; k++) begin
      nk_abs[k] = sq_nk_q[SQN-1][k][NKW-1] ? NKW'(-sq_nk_q[SQN-1][k])
                                           : NKW'(sq_nk_q[SQN-1][k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        g_mag_q[k] <= (MW'(nk_abs[k]) << 8) + MW'(len_s >> 1);
        g_neg_q[k] <= sq_nk_q[SQN-1][k][NKW-1];
      end
      g_len_q <= len_s;
      g_tag_q <= sq_tag_q[SQN-1];
    end
  end

  // division: one quotient bit per stage
  logic [MW-1:0] dv_rem_q [QW][3], dv_rem_d [QW][3];
  logic [QW-1:0] dv_quo_q [QW][3], dv_quo_d [QW][3];
  logic          dv_neg_q [QW][3];
  logic [LW-1:0] dv_len_q [QW];
  tag_t          dv_tag_q [QW];

  always_comb begin
    logic [MW-1:0] rem_p;
    logic [QW-1:0] quo_p;
    logic [LW-1:0] len_p;
    logic [MW-1:0] dsr;
    for (int j = 0; j < QW; j++) begin
      len_p = (j == 0) ? g_len_q : dv_len_q[j-1];
      dsr   = MW'(len_p) << (QW - 1 - j);
      for (int k = 0; k < 3; k++) begin
        if (j == 0) begin
          rem_p = g_mag_q[k];
          quo_p = '0;
        end else begin
          rem_p = dv_rem_q[j-1][k];
          quo_p = dv_quo_q[j-1][k];
        end
        if (rem_p >= dsr) begin
          dv_rem_d[j][k] = rem_p - dsr;
          dv_quo_d[j][k] = {quo_p[QW-2:0], 1'b1};
        end else begin
          dv_rem_d[j][k] = rem_p;
          dv_quo_d[j][k] = {quo_p[QW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < QW; j++) begin
        for (int k = 0; k < 3; k++) begin
          dv_rem_q[j][k] <= dv_rem_d[j][k];
          dv_quo_q[j][k] <= dv_quo_d[j][k];
          dv_neg_q[j][k] <= (j == 0) ? g_neg_q[k] : dv_neg_q[j-1][k];
        end
        dv_len_q[j] <= (j == 0) ? g_len_q : dv_len_q[j-1];
        dv_tag_q[j] <= (j == 0) ? g_tag_q : dv_tag_q[j-1];
      end
    end
  end

  // output: cap select, offset, saturate
  tag_t                 o_tag;
  logic signed [SW-1:0] o_off [3];
  logic signed [SW-1:0] o_base [3];
  logic signed [SW-1:0] o_sum [3];
  logic signed [15:0]   o_pt [3];
  point_t               out_q;

  always_comb begin
    o_tag = dv_tag_q[QW-1];
    for (int k = 0; k < 3; k++) begin
      if (!o_tag.use_rad) begin
        o_off[k] = '0;
      end else if (dv_neg_q[QW-1][k]) begin
        o_off[k] = -$signed(SW'(dv_quo_q[QW-1][k]));
      end else begin
        o_off[k] = $signed(SW'(dv_quo_q[QW-1][k]));
      end
      priority if (o_tag.pos) begin
        o_base[k] = SW'(center_l[k]) + SW'(half_l[k]);
      end else if (o_tag.neg) begin
        o_base[k] = SW'(center_l[k]) - SW'(half_l[k]);
      end else begin
        o_base[k] = SW'(center_l[k]);
      end
      o_sum[k] = o_base[k] + o_off[k];
      priority if (o_sum[k] > SAT_HI) begin
        o_pt[k] = 16'(SAT_HI);
      end else if (o_sum[k] < SAT_LO) begin
        o_pt[k] = 16'(SAT_LO);
      end else begin
        o_pt[k] = 16'(o_sum[k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.point_x <= o_pt[0];
      out_q.point_y <= o_pt[1];
      out_q.point_z <= o_pt[2];
    end
  end

  assign out_data_o = out_q;

endmodule

FILE: sim/cylinder_support_point_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cylinder_support_point_tb
// Self-checking bench for the cylinder support point block: directions are
// pushed through the valid/ready input with random gaps, the output side
// stalls at random, and each support point is compared field by field with
// a bit-exact fixed-point prediction made at the moment the direction is
// accepted. Register writes happen only while the pipeline is empty.
// ----------------------------------------------------------------------------
module cylinder_support_point_tb;
  import csp_pkg::*;

  localparam int  PIPE_LATENCY  = 51;
  localparam int  CYCLE_LIMIT   = 400000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  dir_t                 in_data_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  point_t               out_data_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [VEC_WIDTH-1:0] cfg_data_i = '0;

  logic [VEC_WIDTH-1:0]  cyl_center;
  logic [VEC_WIDTH-1:0]  cyl_axis;
  logic [VEC_WIDTH-1:0]  cyl_half_axis;
  logic [SCAL_WIDTH-1:0] cyl_radius;
  logic [SCAL_WIDTH-1:0] cyl_epsilon;

  point_t expected_points[$];
  int     mismatch_count = 0;
  int     cycle_count = 0;
  int     receiver_hold = 0;
  int     stall_left = 0;
  bit     no_idling = 1'b0;

  cylinder_support_point DUT (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic longint lane(logic [VEC_WIDTH-1:0] packed_vec, int k);
    logic signed [15:0] v;
    v = packed_vec[16*k +: 16];
    return longint'(v);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitval;
    res = 0;
    bitval = 64'd1 << 62;
    while (bitval > v) bitval >>= 2;
    while (bitval != 0) begin
      if (v >= res + bitval) begin
        v   -= res + bitval;
        res  = (res >> 1) + bitval;
      end else begin
        res >>= 1;
      end
      bitval >>= 2;
    end
    return res;
  endfunction

  function automatic longint round_div(longint n, longint unsigned d);
    longint unsigned mag, q;
    mag = (n < 0) ? longint'(-n) : longint'(n);
    q = (mag + d / 2) / d;
    return (n < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [15:0] clamp_coord(longint v);
    longint hi, lo;
    hi = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi[15:0];
    if (v < lo) return lo[15:0];
    return v[15:0];
  endfunction

  function automatic point_t support_point(dir_t dir);
    longint d[3], a[3], r[3];
    longint dot, len2, eps, thr, p, pt;
    longint unsigned root;
    int     side;
    logic signed [15:0] res[3];
    point_t result;
    d[0] = dir.dir_x;
    d[1] = dir.dir_y;
    d[2] = dir.dir_z;
    eps  = longint'(cyl_epsilon);
    thr  = eps <<< UNIT_FRAC_BITS;
    dot  = 0;
    len2 = 0;
    for (int k = 0; k < 3; k++) begin
      a[k] = lane(cyl_axis, k);
      dot += d[k] * a[k];
    end
    side = (dot > thr) ? 1 : ((dot < -thr) ? -1 : 0);
    for (int k = 0; k < 3; k++) begin
      p    = dot * a[k] + (longint'(1) <<< (2 * UNIT_FRAC_BITS - 1));
      r[k] = d[k] - (p >>> (2 * UNIT_FRAC_BITS));
      len2 += r[k] * r[k];
    end
    root = int_sqrt(longint'(len2) << 16);
    for (int k = 0; k < 3; k++) begin
      pt = lane(cyl_center, k) + side * lane(cyl_half_axis, k);
      if (len2 > eps * eps)
        pt += round_div(r[k] * longint'(cyl_radius) * 256, root);
      res[k] = clamp_coord(pt);
    end
    result.point_x = res[0];
    result.point_y = res[1];
    result.point_z = res[2];
    return result;
  endfunction

  function automatic int gap_length();
    int pick;
    if (no_idling) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver: long hold-off when requested, random stalls otherwise
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (receiver_hold > 0) begin
      receiver_hold <= receiver_hold - 1;
      out_ready_i   <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (!no_idling && $urandom_range(0, 4) == 0) begin
      stall_left  <= gap_length();
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    point_t exp_pt;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_points.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected transaction: %h", out_data_o);
      end else begin
        exp_pt = expected_points.pop_front();
        if (exp_pt.point_x !== out_data_o.point_x || exp_pt.point_y !== out_data_o.point_y ||
            exp_pt.point_z !== out_data_o.point_z) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("point mismatch: expected x=%0d y=%0d z=%0d got x=%0d y=%0d z=%0d",
                     exp_pt.point_x, exp_pt.point_y, exp_pt.point_z,
                     out_data_o.point_x, out_data_o.point_y, out_data_o.point_z);
        end
      end
    end
  end

  task automatic send_direction(input int x, input int y, input int z);
    int gap;
    gap = gap_length();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i        = 1'b1;
    in_data_i.dir_x   = 16'(x);
    in_data_i.dir_y   = 16'(y);
    in_data_i.dir_z   = 16'(z);
    do @(posedge clk_i); while (!in_ready_o);
    expected_points.push_back(support_point(in_data_i));
  endtask

  task automatic drain_pipeline();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    wait (expected_points.size() == 0);
    repeat (PIPE_LATENCY + 10) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [VEC_WIDTH-1:0] value);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_CENTER:    cyl_center    = value;
      CFG_AXIS:      cyl_axis      = value;
      CFG_HALF_AXIS: cyl_half_axis = value;
      CFG_RADIUS:    cyl_radius    = value[SCAL_WIDTH-1:0];
      CFG_EPSILON:   cyl_epsilon   = value[SCAL_WIDTH-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic logic [VEC_WIDTH-1:0] pack3(int x, int y, int z);
    logic [15:0] px, py, pz;
    px = 16'(x);
    py = 16'(y);
    pz = 16'(z);
    return {pz, py, px};
  endfunction

  task automatic set_cylinder(input logic [VEC_WIDTH-1:0] center, input logic [VEC_WIDTH-1:0] axis,
                              input logic [VEC_WIDTH-1:0] half, input logic [VEC_WIDTH-1:0] rad,
                              input logic [VEC_WIDTH-1:0] eps);
    drain_pipeline();
    write_register(CFG_CENTER, center);
    write_register(CFG_AXIS, axis);
    write_register(CFG_HALF_AXIS, half);
    write_register(CFG_RADIUS, rad);
    write_register(CFG_EPSILON, eps);
  endtask

  function automatic int rand_coord();
    return $urandom_range(0, 32768) - 16384;
  endfunction

  task automatic send_random_direction();
    int pick;
    int s;
    pick = $urandom_range(0, 9);
    s = ($urandom_range(0, 1) != 0) ? 16384 : -16384;
    if (pick < 5)
      send_direction(rand_coord(), rand_coord(), rand_coord());
    else if (pick < 7)
      send_direction(rand_coord() / 2, rand_coord() / 2, rand_coord() / 2);
    else if (pick == 7)
      case ($urandom_range(0, 2))
        0: send_direction(s, 0, 0);
        1: send_direction(0, s, 0);
        default: send_direction(0, 0, s);
      endcase
    else
      send_direction($urandom_range(0, 8) - 4, $urandom_range(0, 8) - 4,
                     $urandom_range(0, 8) - 4);
  endtask

  task automatic test_reset_values();
    cyl_center    = '0;
    cyl_axis      = '0;
    cyl_half_axis = '0;
    cyl_radius    = '0;
    cyl_epsilon   = EPSILON_RESET;
    send_direction(16384, 0, 0);
    send_direction(1, -1, 0);
    send_direction(0, 0, 0);
  endtask

  task automatic test_directed();
    set_cylinder(pack3(256, -512, 1024), pack3(0, 0, 16384), pack3(0, 0, 768), 640, 2);
    send_direction(0, 0, 16384);
    send_direction(0, 0, -16384);
    send_direction(16384, 0, 0);
    send_direction(-16384, 0, 0);
    send_direction(0, -16384, 0);
    send_direction(11585, 0, 11585);
    send_direction(-16384, -16384, -16384);
    send_direction(16384, 16384, 16384);
    send_direction(0, 0, 0);
    send_direction(1, 1, 2);
    send_direction(3, 0, 0);
    drain_pipeline();
    write_register(CFG_UNUSED_IDX, {VEC_WIDTH{1'b1}});
    send_direction(1, 0, 0);
    set_cylinder(pack3(256, -512, 1024), pack3(0, 0, 16384), pack3(0, 0, 768), 640, 0);
    send_direction(1, 0, 0);
    send_direction(0, 0, 1);
    send_direction(0, 0, -1);
    send_direction(0, 0, 0);
    // saturate against the coordinate limits
    set_cylinder(pack3(32767, -32768, 32000), pack3(0, 16384, 0), pack3(32767, -32768, 32767),
                 32767, 16384);
    send_direction(16384, -16384, 16384);
    send_direction(-16384, 16384, 0);
    // non-unit axis
    set_cylinder(pack3(-100, 100, 0), pack3(-32768, 32767, -32768), pack3(500, 0, -500), 300, 100);
    send_direction(16384, 16384, -16384);
    send_direction(-16384, 0, 16384);
  endtask

  task automatic test_backpressure();
    set_cylinder(pack3(0, 0, 0), pack3(9459, 9459, 9459), pack3(300, 300, 300), 512, 16);
    no_idling = 1'b1;
    receiver_hold = 400;
    repeat (90) send_random_direction();
    no_idling = 1'b0;
  endtask

  task automatic test_random_phase(input int count);
    set_cylinder(VEC_WIDTH'({$urandom, $urandom}), VEC_WIDTH'({$urandom, $urandom}),
                 VEC_WIDTH'({$urandom, $urandom}), VEC_WIDTH'({$urandom, $urandom}),
                 VEC_WIDTH'($urandom_range(0, 16384)));
    repeat (count) send_random_direction();
  endtask

  task automatic test_random_unit_axis(input int count);
    int s;
    s = ($urandom_range(0, 1) != 0) ? 16384 : -16384;
    set_cylinder(pack3($urandom_range(0, 8000) - 4000, $urandom_range(0, 8000) - 4000, 0),
                 ($urandom_range(0, 1) != 0) ? pack3(0, s, 0) : pack3(s, 0, 0),
                 pack3($urandom_range(0, 2000) - 1000, $urandom_range(0, 2000) - 1000, 0),
                 VEC_WIDTH'($urandom_range(0, 32767)), VEC_WIDTH'($urandom_range(0, 64)));
    repeat (count) send_random_direction();
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_values();
    test_directed();
    test_backpressure();
    test_random_unit_axis(60);
    test_random_phase(50);
    no_idling = 1'b1;
    test_random_unit_axis(40);
    no_idling = 1'b0;
    test_random_phase(50);
    test_random_unit_axis(60);
    set_cylinder(pack3(0, 0, 0), pack3(16384, 0, 0), pack3(0, 0, 0), 32767, 16384);
    repeat (40) send_random_direction();
    set_cylinder(pack3(-32768, -32768, -32768), pack3(0, 0, -16384), pack3(-32768, -32768, 32767),
                 0, 0);
    repeat (40) send_random_direction();
    drain_pipeline();
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
